// ----- rtl/motor_speed_loop_with_slip_monitor_top_defines.svh -----
// Assertion macros shared by the motor speed loop RTL.
`ifndef MOTOR_SPEED_LOOP_WITH_SLIP_MONITOR_TOP_DEFINES_SVH
`define MOTOR_SPEED_LOOP_WITH_SLIP_MONITOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MSL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MSL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MSL_ASSERT(lbl, prop, msg)
`define MSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/msl_pkg.sv -----
// Package for the motor speed loop: widths, codes, types and reset values.
package msl_pkg;

   localparam int POSITION_BITS = 32;
   localparam int DT_W          = 20;
   localparam int MUL_BITS      = 20;
   localparam logic [MUL_BITS-1:0] MUL_CONST = 20'd1000000;
   localparam int MUL_IDX_W     = $clog2(MUL_BITS);
   localparam int NUM_W         = POSITION_BITS + MUL_BITS;
   localparam int Q_BITS        = 33;
   localparam int CNT_W         = $clog2(Q_BITS + 1);
   localparam int VEL_W         = 32;
   localparam int TGT_W         = 24;
   localparam int PID_W         = 17;
   localparam int ERR_W         = 33;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [TGT_W-1:0] SLIP_MIN_TARGET = 24'd50;
   localparam logic [6:0]       DUTY_MAX        = 7'd100;
   localparam logic signed [VEL_W-1:0] VEL_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN  = 32'sh8000_0000;

   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_STOP   = 2'd1;
   localparam logic [1:0] KIND_BRAKE  = 2'd2;

   localparam logic [1:0] MODE_COAST = 2'd0;
   localparam logic [1:0] MODE_BRAKE = 2'd1;
   localparam logic [1:0] MODE_DRIVE = 2'd2;

   localparam logic [1:0] GRADE_NONE = 2'd0;
   localparam logic [1:0] GRADE_WARN = 2'd1;
   localparam logic [1:0] GRADE_CRIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLIP_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIP_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIP_TIME_MS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_CODE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD_CODE  = 3'd4;

   localparam logic        RST_SLIP_ENABLE    = 1'b1;
   localparam logic [7:0]  RST_SLIP_THRESHOLD = 8'd90;
   localparam logic [15:0] RST_SLIP_TIME_MS   = 16'd500;
   localparam logic [7:0]  RST_FORWARD_CODE   = 8'd1;
   localparam logic [7:0]  RST_BACKWARD_CODE  = 8'd2;

   typedef logic signed [POSITION_BITS-1:0] position_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VEL_START,
      ST_VEL_WAIT,
      ST_ERR,
      ST_SLIP,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      VU_IDLE,
      VU_MUL,
      VU_CHECK,
      VU_DIV,
      VU_FIN
   } vel_state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic clear;
   } slip_ctrl_type;

   typedef struct packed {
      logic        enable;
      logic [7:0]  threshold;
      logic [15:0] time_ms;
   } slip_cfg_type;

endpackage

// ----- rtl/msl_velocity_unit.sv -----
// Serial velocity unit: shift-add scale by 1e6, then restoring divide, one adder.
`include "motor_speed_loop_with_slip_monitor_top_defines.svh"

module msl_velocity_unit
   import msl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  position_type            delta,
   input  logic [DT_W-1:0]         dt,
   output logic                    done,
   output logic signed [VEL_W-1:0] velocity
);

   vel_state_type state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        acc_ff, acc_in;
   logic [NUM_W-1:0]        mcand_ff, mcand_in;
   logic [DT_W-1:0]         rem_ff, rem_in;
   logic [Q_BITS-1:0]       quo_ff, quo_in;
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic                    neg_ff, neg_in;
   logic                    sat_ff, sat_in;
   logic                    zero_ff, zero_in;
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic                    done_ff, done_in;

   logic [NUM_W-1:0]          add_a, add_b, add_y;
   logic                      add_sub;
   logic [DT_W:0]             trial;
   logic [POSITION_BITS-1:0]  delta_mag;
   logic [NUM_W-Q_BITS-1:0]   acc_hi;
   logic                      borrow;
   logic                      big;

   assign trial     = {rem_ff, quo_ff[Q_BITS-1]};
   assign delta_mag = delta[POSITION_BITS-1] ? (~delta + 1'b1) : delta;
   assign acc_hi    = acc_ff[NUM_W-1:Q_BITS];
   assign borrow    = add_y[NUM_W-1];
   assign big       = (quo_ff[Q_BITS-1:VEL_W-1] != '0) || sat_ff;

   // shared adder
   always_comb begin
      if (state_ff == VU_MUL) begin
         add_a   = acc_ff;
         add_b   = MUL_CONST[cnt_ff[MUL_IDX_W-1:0]] ? mcand_ff : '0;
         add_sub = 1'b0;
      end else begin
         add_a   = NUM_W'(trial);
         add_b   = NUM_W'(dt_ff);
         add_sub = 1'b1;
      end
      add_y = add_a + (add_sub ? ~add_b : add_b) + NUM_W'(add_sub);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         VU_IDLE: begin
            if (start) begin
               state_in = (dt == '0) ? VU_FIN : VU_MUL;
            end
         end
         VU_MUL: begin
            if (cnt_ff == CNT_W'(MUL_BITS - 1)) begin
               state_in = VU_CHECK;
            end
         end
         VU_CHECK: begin
            state_in = (NUM_W'(acc_hi) >= NUM_W'(dt_ff)) ? VU_FIN : VU_DIV;
         end
         VU_DIV: begin
            if (cnt_ff == CNT_W'(Q_BITS - 1)) begin
               state_in = VU_FIN;
            end
         end
         VU_FIN:  state_in = VU_IDLE;
         default: state_in = VU_IDLE;
      endcase
   end

   always_comb begin
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dt_in    = dt_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      zero_in  = zero_ff;
      vel_in   = vel_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         VU_IDLE: begin
            if (start) begin
               cnt_in   = '0;
               acc_in   = '0;
               mcand_in = NUM_W'(delta_mag);
               dt_in    = dt;
               neg_in   = delta[POSITION_BITS-1];
               sat_in   = 1'b0;
               zero_in  = (dt == '0);
            end
         end
         VU_MUL: begin
            acc_in   = add_y;
            mcand_in = mcand_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
         end
         VU_CHECK: begin
            sat_in = (NUM_W'(acc_hi) >= NUM_W'(dt_ff));
            rem_in = DT_W'(acc_hi);
            quo_in = acc_ff[Q_BITS-1:0];
            cnt_in = '0;
         end
         VU_DIV: begin
            rem_in = borrow ? trial[DT_W-1:0] : add_y[DT_W-1:0];
            quo_in = {quo_ff[Q_BITS-2:0], ~borrow};
            cnt_in = cnt_ff + 1'b1;
         end
         VU_FIN: begin
            done_in = 1'b1;
            if (zero_ff) begin
               vel_in = '0;
            end else if (neg_ff) begin
               vel_in = big ? VEL_MIN : VEL_W'(~quo_ff[VEL_W-1:0] + 1'b1);
            end else begin
               vel_in = big ? VEL_MAX : VEL_W'(quo_ff[VEL_W-1:0]);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dt_ff    <= dt_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      zero_ff  <= zero_in;
      vel_ff   <= vel_in;
   end

   assign done     = done_ff;
   assign velocity = vel_ff;

   `MSL_ASSERT(a_rem_below_dt, state_ff == VU_DIV |-> rem_ff < dt_ff, "remainder not below divisor")
   `MSL_ASSERT(a_done_pulse, done_ff |=> !done_ff, "done held longer than one cycle")
   `MSL_ASSERT(a_start_idle, start |-> state_ff == VU_IDLE, "start while velocity unit busy")

endmodule

// ----- rtl/msl_slip_monitor.sv -----
// Slip monitor: tracking error, persistence timer and slip grade.
module msl_slip_monitor
   import msl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  slip_ctrl_type           ctrl,
   input  slip_cfg_type            cfg,
   input  logic signed [TGT_W-1:0] target,
   input  logic signed [VEL_W-1:0] velocity,
   input  logic [31:0]             now_ms,
   output logic [1:0]              grade
);

   logic [ERR_W-1:0] err_ff, err_in;
   logic             timing_ff, timing_in;
   logic [31:0]      start_ff, start_in;
   logic [1:0]       grade_ff, grade_in;

   logic signed [ERR_W:0] diff;
   logic [TGT_W-1:0]      atgt;
   logic [31:0]           limit;
   logic [31:0]           elapsed;
   logic                  over, crit, expired, small_tgt;

   assign diff      = (ERR_W+1)'(target) - (ERR_W+1)'(velocity);
   assign atgt      = target[TGT_W-1] ? TGT_W'(~target + 1'b1) : TGT_W'(target);
   assign limit     = {24'd0, cfg.threshold} * {8'd0, atgt};
   assign over      = {err_ff, 8'd0} > (ERR_W+8)'(limit);
   assign crit      = {err_ff, 1'b0} > (ERR_W+1)'(atgt);
   assign elapsed   = now_ms - start_ff;
   assign expired   = elapsed >= 32'(cfg.time_ms);
   assign small_tgt = atgt < SLIP_MIN_TARGET;

   always_comb begin
      err_in    = err_ff;
      timing_in = timing_ff;
      start_in  = start_ff;
      grade_in  = grade_ff;
      if (ctrl.capture) begin
         err_in = diff[ERR_W] ? ERR_W'(-diff) : ERR_W'(diff);
      end
      if (ctrl.clear || (ctrl.eval && (!cfg.enable || small_tgt || !over))) begin
         timing_in = 1'b0;
         start_in  = '0;
         grade_in  = GRADE_NONE;
      end else if (ctrl.eval) begin
         if (!timing_ff) begin
            timing_in = 1'b1;
            start_in  = now_ms;
            grade_in  = GRADE_NONE;
         end else if (expired) begin
            grade_in = crit ? GRADE_CRIT : GRADE_WARN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= 1'b0;
         grade_ff  <= GRADE_NONE;
      end else begin
         timing_ff <= timing_in;
         grade_ff  <= grade_in;
      end
      err_ff   <= err_in;
      start_ff <= start_in;
   end

   assign grade = grade_ff;

endmodule

// ----- rtl/motor_speed_loop_with_slip_monitor_top.sv -----
// Top level of the motor speed loop with slip monitor.
// Update request: velocity from 20 shift-add and 33 divide steps on the shared adder;
// the divide is skipped when the quotient saturates, and both when elapsed time is zero.
// Stop and brake requests go straight to the output register. One request in flight;
// a new request is accepted only once the last response is loaded, so a response stall holds it.
// Synchronous active-high reset clears position, velocity and slip state, loads CSR defaults.
`include "motor_speed_loop_with_slip_monitor_top_defines.svh"

module motor_speed_loop_with_slip_monitor_top
   import msl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  logic signed [31:0]      req_encoder_position,
   input  logic [DT_W-1:0]         req_elapsed_us,
   input  logic [31:0]             req_now_ms,
   input  logic signed [TGT_W-1:0] req_target_velocity,
   input  logic signed [PID_W-1:0] req_pid_output,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_drive_mode,
   output logic [7:0]              rsp_direction_code,
   output logic [6:0]              rsp_duty_percent,
   output logic signed [VEL_W-1:0] rsp_measured_velocity,
   output logic [1:0]              rsp_slip_level,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   top_state_type state_ff, state_in;

   slip_cfg_type slip_cfg_ff, slip_cfg_in;
   logic [7:0]   fwd_code_ff, fwd_code_in;
   logic [7:0]   bwd_code_ff, bwd_code_in;

   logic [1:0]              kind_ff;
   position_type            last_position_ff;
   position_type            delta_ff;
   logic [DT_W-1:0]         dt_ff;
   logic [31:0]             now_ff;
   logic signed [TGT_W-1:0] target_ff;
   logic signed [PID_W-1:0] pid_ff;
   logic signed [VEL_W-1:0] last_velocity_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              mode_ff, mode_in;
   logic [7:0]              dir_ff, dir_in;
   logic [6:0]              duty_ff, duty_in;
   logic signed [VEL_W-1:0] vel_out_ff;
   logic [1:0]              slip_out_ff;

   logic                    accept, is_update, out_load;
   position_type            pos_ext;
   logic                    vu_start, vu_done;
   logic signed [VEL_W-1:0] vu_velocity;
   slip_ctrl_type           slip_ctrl;
   logic [1:0]              slip_grade;
   logic [PID_W-1:0]        pid_mag;
   logic [8:0]              duty_raw;
   logic                    tgt_zero;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_update = (req_kind == KIND_UPDATE);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign pos_ext   = POSITION_BITS'(req_encoder_position);
   assign vu_start  = (state_ff == ST_VEL_START);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_update ? ST_VEL_START : ST_OUT;
            end
         end
         ST_VEL_START: state_in = ST_VEL_WAIT;
         ST_VEL_WAIT: begin
            if (vu_done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR:  state_in = ST_SLIP;
         ST_SLIP: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      slip_ctrl.capture = (state_ff == ST_ERR);
      slip_ctrl.eval    = (state_ff == ST_SLIP);
      slip_ctrl.clear   = accept && !is_update;
   end

   // CSR writes
   always_comb begin
      slip_cfg_in = slip_cfg_ff;
      fwd_code_in = fwd_code_ff;
      bwd_code_in = bwd_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLIP_ENABLE:    slip_cfg_in.enable    = csr_wdata[0];
            CSR_SLIP_THRESHOLD: slip_cfg_in.threshold = csr_wdata[7:0];
            CSR_SLIP_TIME_MS:   slip_cfg_in.time_ms   = csr_wdata[15:0];
            CSR_FORWARD_CODE:   fwd_code_in           = csr_wdata[7:0];
            CSR_BACKWARD_CODE:  bwd_code_in           = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // drive command
   assign pid_mag  = pid_ff[PID_W-1] ? PID_W'(~pid_ff + 1'b1) : PID_W'(pid_ff);
   assign duty_raw = pid_mag[PID_W-1:8];
   assign tgt_zero = (target_ff == '0);

   always_comb begin
      mode_in = (kind_ff == KIND_BRAKE) ? MODE_BRAKE : MODE_COAST;
      dir_in  = '0;
      duty_in = '0;
      if (kind_ff == KIND_UPDATE) begin
         mode_in = MODE_COAST;
         if (duty_raw != '0 && !tgt_zero) begin
            mode_in = MODE_DRIVE;
            duty_in = (duty_raw > 9'(DUTY_MAX)) ? DUTY_MAX : duty_raw[6:0];
            dir_in  = target_ff[TGT_W-1] ? bwd_code_ff : fwd_code_ff;
         end
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slip_cfg_ff      <= '{enable: RST_SLIP_ENABLE, threshold: RST_SLIP_THRESHOLD,
                               time_ms: RST_SLIP_TIME_MS};
         fwd_code_ff      <= RST_FORWARD_CODE;
         bwd_code_ff      <= RST_BACKWARD_CODE;
         last_position_ff <= '0;
         last_velocity_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slip_cfg_ff  <= slip_cfg_in;
         fwd_code_ff  <= fwd_code_in;
         bwd_code_ff  <= bwd_code_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && is_update) begin
            last_position_ff <= pos_ext;
         end
         if (vu_done) begin
            last_velocity_ff <= vu_velocity;
         end
      end
      if (accept) begin
         kind_ff   <= req_kind;
         delta_ff  <= pos_ext - last_position_ff;
         dt_ff     <= req_elapsed_us;
         now_ff    <= req_now_ms;
         target_ff <= req_target_velocity;
         pid_ff    <= req_pid_output;
      end
      if (out_load) begin
         mode_ff     <= mode_in;
         dir_ff      <= dir_in;
         duty_ff     <= duty_in;
         vel_out_ff  <= last_velocity_ff;
         slip_out_ff <= slip_grade;
      end
   end

   msl_velocity_unit u_velocity (
      .clock    (clock),
      .reset    (reset),
      .start    (vu_start),
      .delta    (delta_ff),
      .dt       (dt_ff),
      .done     (vu_done),
      .velocity (vu_velocity)
   );

   msl_slip_monitor u_slip (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (slip_ctrl),
      .cfg      (slip_cfg_ff),
      .target   (target_ff),
      .velocity (last_velocity_ff),
      .now_ms   (now_ff),
      .grade    (slip_grade)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drive_mode        = mode_ff;
   assign rsp_direction_code    = dir_ff;
   assign rsp_duty_percent      = duty_ff;
   assign rsp_measured_velocity = vel_out_ff;
   assign rsp_slip_level        = slip_out_ff;

   `MSL_ASSERT(a_drive_duty, rsp_valid_ff && mode_ff == MODE_DRIVE |-> duty_ff != '0 && duty_ff <= DUTY_MAX, "drive with duty out of range")
   `MSL_ASSERT(a_idle_no_drive, rsp_valid_ff && mode_ff != MODE_DRIVE |-> dir_ff == '0 && duty_ff == '0, "direction or duty set without drive")
   `MSL_ASSERT(a_vel_done_wait, vu_done |-> state_ff == ST_VEL_WAIT, "velocity result outside wait state")

endmodule

// ----- sim/motor_speed_loop_with_slip_monitor_top_tb.sv -----
// Self-checking testbench for the motor speed loop with slip monitor.
`timescale 1ns / 100ps

module motor_speed_loop_with_slip_monitor_top_tb
   import msl_pkg::*;
();

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int SCRIPT_LEN = 19;
   localparam int RSP_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pos;
      logic [DT_W-1:0]    dt;
      logic [31:0]        now;
      logic signed [23:0] target;
      logic signed [16:0] pid;
   } motor_cmd_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         dir;
      logic [6:0]         duty;
      logic signed [31:0] vel;
      logic [1:0]         grade;
   } drive_type;

   typedef struct packed {
      motor_cmd_type cmd;
      logic          known;
      drive_type     want;
   } script_row_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  thr;
      logic [15:0] ms;
      logic [7:0]  fwd;
      logic [7:0]  bwd;
   } csr_set_type;

   // directed requests; responses filled in where they follow directly
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{KIND_STOP, 32'sd0, 20'd0, 32'd0, 24'sd0, 17'sd0}, 1'b1,
        '{MODE_COAST, 8'd0, 7'd0, 32'sd0, GRADE_NONE}},
      '{'{KIND_BRAKE, 32'sd0, 20'd0, 32'd0, 24'sd0, 17'sd0}, 1'b1,
        '{MODE_BRAKE, 8'd0, 7'd0, 32'sd0, GRADE_NONE}},
      '{'{KIND_SPARE, 32'sd0, 20'd0, 32'd0, 24'sd0, 17'sd0}, 1'b1,
        '{MODE_COAST, 8'd0, 7'd0, 32'sd0, GRADE_NONE}},
      '{'{KIND_UPDATE, 32'sd0, 20'd0, 32'd0, 24'sd0, 17'sd0}, 1'b1,
        '{MODE_COAST, 8'd0, 7'd0, 32'sd0, GRADE_NONE}},
      '{'{KIND_UPDATE, 32'sh8000_0000, 20'd1, 32'd10, 24'sd0, 17'h10000}, 1'b1,
        '{MODE_COAST, 8'd0, 7'd0, VEL_MIN, GRADE_NONE}},
      '{'{KIND_UPDATE, 32'sh7FFF_FFFF, 20'd1, 32'd20, -24'sd1, 17'sd65535}, 1'b1,
        '{MODE_DRIVE, RST_BACKWARD_CODE, DUTY_MAX, -32'sd1000000, GRADE_NONE}},
      '{'{KIND_UPDATE, 32'sh8000_0000, 20'd1, 32'd30, 24'sd8388607, 17'h10000}, 1'b1,
        '{MODE_DRIVE, RST_FORWARD_CODE, DUTY_MAX, 32'sd1000000, GRADE_NONE}},
      '{'{KIND_UPDATE, 32'sd0, 20'hFFFFF, 32'd529, 24'sd8388607, 17'sd256}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd0, 20'd1000, 32'd530, 24'h800000, 17'sd255}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd0, 20'd1000, 32'd531, 24'h800000, -17'sd256}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd0, 20'd1000, 32'd532, -24'sd49, 17'sd4096}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd0, 20'd1000, 32'hFFFF_FFF0, 24'sd50, -17'sd255}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd0, 20'd1000, 32'd484, 24'sd50, 17'sd0}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd600, 20'd1000000, 32'd485, 24'sd1000, 17'sd6400}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd1600, 20'd1000000, 32'd486, 24'sd1000, 17'sd6400}, 1'b0, '0},
      '{'{KIND_STOP, 32'sd77, 20'd5, 32'd9, 24'sd9, 17'sd9}, 1'b0, '0},
      '{'{KIND_BRAKE, 32'sd77, 20'd5, 32'd9, 24'sd9, 17'sd9}, 1'b0, '0},
      '{'{KIND_UPDATE, 32'sd5000, 20'd0, 32'd487, 24'sd100, 17'sd384}, 1'b0, '0},
      '{'{KIND_UPDATE, -32'sd5000, 20'd4000, 32'd488, -24'sd50, 17'h10001}, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_kind = KIND_UPDATE;
   logic signed [31:0]      req_encoder_position = '0;
   logic [DT_W-1:0]         req_elapsed_us = '0;
   logic [31:0]             req_now_ms = '0;
   logic signed [TGT_W-1:0] req_target_velocity = '0;
   logic signed [PID_W-1:0] req_pid_output = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_drive_mode;
   logic [7:0]              rsp_direction_code;
   logic [6:0]              rsp_duty_percent;
   logic signed [VEL_W-1:0] rsp_measured_velocity;
   logic [1:0]              rsp_slip_level;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // loop model state and registers
   logic [31:0]        last_pos_m = '0;
   logic signed [31:0] last_vel_m = '0;
   logic               slip_armed = 1'b0;
   logic [31:0]        slip_t0 = '0;
   logic [1:0]         slip_grade_m = GRADE_NONE;
   logic               cfg_slip_en = RST_SLIP_ENABLE;
   logic [7:0]         cfg_slip_thr = RST_SLIP_THRESHOLD;
   logic [15:0]        cfg_slip_ms = RST_SLIP_TIME_MS;
   logic [7:0]         cfg_fwd_code = RST_FORWARD_CODE;
   logic [7:0]         cfg_bwd_code = RST_BACKWARD_CODE;

   // motion profile for well-formed update sequences
   logic [31:0]        run_pos = '0;
   logic [31:0]        run_now = '0;
   logic signed [23:0] run_target = '0;
   int                 run_ratio = 100;
   int                 run_left = 0;

   drive_type drive_outputs_due [$];
   drive_type rsp_seen;
   logic   sender_idles = 1'b1;
   logic   receiver_idles = 1'b1;
   logic   rsp_hold_req = 1'b0;
   int     rsp_hold_left = 0;
   int     mismatch_count = 0;
   int     drives_checked = 0;
   int     updates_sent = 0;
   int     halts_sent = 0;
   int     csr_writes = 0;
   int     warn_seen = 0;
   int     crit_seen = 0;

   motor_speed_loop_with_slip_monitor_top DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_encoder_position  (req_encoder_position),
      .req_elapsed_us        (req_elapsed_us),
      .req_now_ms            (req_now_ms),
      .req_target_velocity   (req_target_velocity),
      .req_pid_output        (req_pid_output),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_mode        (rsp_drive_mode),
      .rsp_direction_code    (rsp_direction_code),
      .rsp_duty_percent      (rsp_duty_percent),
      .rsp_measured_velocity (rsp_measured_velocity),
      .rsp_slip_level        (rsp_slip_level),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("motor_speed_loop_with_slip_monitor_top regression: fail");
      $finish;
   end

   function automatic void clear_slip();
      slip_armed = 1'b0;
      slip_t0 = '0;
      slip_grade_m = GRADE_NONE;
   endfunction

   function automatic drive_type next_drive_output(input motor_cmd_type c);
      drive_type          o;
      logic signed [31:0] delta;
      logic signed [23:0] tgt;
      logic signed [16:0] pid;
      logic [31:0]        since_ms;
      longint unsigned    mag_delta;
      longint unsigned    quot;
      longint             vel;
      longint             diff;
      longint             err_abs;
      longint             tgt_abs;
      int                 pid_abs;
      o = '0;
      tgt = c.target;
      pid = c.pid;
      if (c.kind != KIND_UPDATE) begin
         o.mode = (c.kind == KIND_BRAKE) ? MODE_BRAKE : MODE_COAST;
         clear_slip();
      end else begin
         delta = c.pos - last_pos_m;
         last_pos_m = c.pos;
         vel = 0;
         if (c.dt != 0) begin
            mag_delta = (delta < 0) ? -longint'(delta) : longint'(delta);
            quot = mag_delta * 1000000 / c.dt;
            vel = (delta < 0) ? -longint'(quot) : longint'(quot);
            if (vel > longint'(VEL_MAX)) vel = longint'(VEL_MAX);
            if (vel < longint'(VEL_MIN)) vel = longint'(VEL_MIN);
         end
         last_vel_m = vel[31:0];
         pid_abs = (pid < 0) ? -int'(pid) : int'(pid);
         if (pid_abs >= 256 && tgt != 0) begin
            o.mode = MODE_DRIVE;
            o.duty = ((pid_abs >> 8) > 100) ? DUTY_MAX : 7'(pid_abs >> 8);
            o.dir = (tgt > 0) ? cfg_fwd_code : cfg_bwd_code;
         end
         tgt_abs = (tgt < 0) ? -longint'(tgt) : longint'(tgt);
         if (!cfg_slip_en || tgt_abs < longint'(SLIP_MIN_TARGET)) begin
            clear_slip();
         end else begin
            diff = longint'(tgt) - vel;
            err_abs = (diff < 0) ? -diff : diff;
            if (err_abs * 256 > longint'(cfg_slip_thr) * tgt_abs) begin
               since_ms = c.now - slip_t0;
               if (!slip_armed) begin
                  slip_armed = 1'b1;
                  slip_t0 = c.now;
                  slip_grade_m = GRADE_NONE;
               end else if (since_ms >= cfg_slip_ms) begin
                  slip_grade_m = (err_abs * 2 > tgt_abs) ? GRADE_CRIT : GRADE_WARN;
               end
            end else begin
               clear_slip();
            end
         end
      end
      o.vel = last_vel_m;
      o.grade = slip_grade_m;
      return o;
   endfunction

   function automatic motor_cmd_type make_cmd();
      motor_cmd_type c;
      int            pick;
      int            sel;
      int            mag;
      longint        actual;
      pick = $urandom_range(99);
      c.kind = KIND_UPDATE;
      c.pos = $urandom;
      c.dt = 20'($urandom);
      c.now = $urandom;
      c.target = 24'($urandom);
      c.pid = 17'($urandom);
      if (pick < 2) begin
         c.kind = KIND_STOP;
      end else if (pick < 4) begin
         c.kind = KIND_BRAKE;
      end else if (pick < 6) begin
         c.kind = KIND_SPARE;
      end else if (pick < 14) begin
         run_pos = c.pos;
      end else begin
         if (run_left == 0) begin
            case ($urandom_range(9))
               0: run_target = 24'($urandom_range(0, 49));
               1, 2: run_target = 24'($urandom);
               default: run_target = 24'($urandom_range(50, 20000));
            endcase
            if ($urandom_range(1) == 1) run_target = -run_target;
            case ($urandom_range(7))
               4: run_ratio = 0;
               5: run_ratio = 40;
               6: run_ratio = 60;
               7: run_ratio = ($urandom_range(1) == 1) ? 200 : -100;
               default: run_ratio = 100;
            endcase
            run_left = $urandom_range(5, 60);
         end
         run_left--;
         sel = $urandom_range(99);
         if (sel < 3) c.dt = '0;
         else if (sel < 6) c.dt = 20'($urandom_range(500000, 1048575));
         else c.dt = 20'($urandom_range(100, 20000));
         actual = longint'(run_target) * run_ratio / 100
                  + longint'($urandom_range(0, 20)) - 10;
         run_pos = run_pos + 32'(actual * longint'(c.dt) / 1000000);
         run_now = run_now + 32'(c.dt / 1000)
                   + (($urandom_range(99) < 3) ? $urandom_range(0, 70000)
                                                : $urandom_range(0, 3));
         c.pos = run_pos;
         c.now = run_now;
         c.target = run_target;
         case ($urandom_range(3))
            0: mag = $urandom_range(0, 511);
            1: mag = $urandom_range(256, 25600);
            2: mag = $urandom_range(25600, 65535);
            default: mag = -1;
         endcase
         if (mag >= 0) c.pid = ($urandom_range(1) == 1) ? -17'(mag) : 17'(mag);
      end
      return c;
   endfunction

   function automatic csr_set_type pick_csr(input int ph);
      csr_set_type s;
      case (ph)
         0: s = '{1'b1, 8'd0, 16'd0, 8'hFF, 8'h00};
         1: s = '{1'b1, 8'hFF, 16'hFFFF, 8'h00, 8'hFF};
         2: s = '{1'b0, 8'd90, 16'd10, 8'd1, 8'd2};
         3: s = '{RST_SLIP_ENABLE, RST_SLIP_THRESHOLD, RST_SLIP_TIME_MS,
                  RST_FORWARD_CODE, RST_BACKWARD_CODE};
         default: begin
            s.en = ($urandom_range(9) != 0);
            s.thr = 8'($urandom_range(0, 200));
            s.ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            s.fwd = 8'($urandom);
            s.bwd = 8'($urandom);
         end
      endcase
      return s;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SLIP_ENABLE: cfg_slip_en = data[0];
         CSR_SLIP_THRESHOLD: cfg_slip_thr = data[7:0];
         CSR_SLIP_TIME_MS: cfg_slip_ms = data;
         CSR_FORWARD_CODE: cfg_fwd_code = data[7:0];
         CSR_BACKWARD_CODE: cfg_bwd_code = data[7:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic send_cmd(input motor_cmd_type c, input logic known, input drive_type want);
      drive_type p;
      while (sender_idles && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= c.kind;
      req_encoder_position <= c.pos;
      req_elapsed_us <= c.dt;
      req_now_ms <= c.now;
      req_target_velocity <= c.target;
      req_pid_output <= c.pid;
      do @(posedge clock); while (!req_ready);
      p = next_drive_output(c);
      drive_outputs_due.push_back(known ? want : p);
      if (c.kind == KIND_UPDATE) updates_sent++;
      else halts_sent++;
   endtask

   task automatic settle_outputs();
      req_valid <= 1'b0;
      do @(posedge clock); while (drive_outputs_due.size() != 0);
   endtask

   task automatic check_drive(input drive_type got);
      drive_type want;
      if (drive_outputs_due.size() == 0) begin
         $error("unexpected response: drive_mode %0d, measured_velocity %0d",
                got.mode, $signed(got.vel));
         mismatch_count++;
         return;
      end
      want = drive_outputs_due.pop_front();
      drives_checked++;
      if (got.grade == GRADE_WARN) warn_seen++;
      if (got.grade == GRADE_CRIT) crit_seen++;
      if (got.mode !== want.mode) begin
         $error("drive_mode: expected %0d, got %0d", want.mode, got.mode);
         mismatch_count++;
      end
      if (got.dir !== want.dir) begin
         $error("direction_code: expected %0d, got %0d", want.dir, got.dir);
         mismatch_count++;
      end
      if (got.duty !== want.duty) begin
         $error("duty_percent: expected %0d, got %0d", want.duty, got.duty);
         mismatch_count++;
      end
      if (got.vel !== want.vel) begin
         $error("measured_velocity: expected %0d, got %0d",
                $signed(want.vel), $signed(got.vel));
         mismatch_count++;
      end
      if (got.grade !== want.grade) begin
         $error("slip_level: expected %0d, got %0d", want.grade, got.grade);
         mismatch_count++;
      end
   endtask

   // response side: checks, random stalls, long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            rsp_seen = '{rsp_drive_mode, rsp_direction_code, rsp_duty_percent,
                         rsp_measured_velocity, rsp_slip_level};
            check_drive(rsp_seen);
         end
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_hold_left = RSP_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(receiver_idles && $urandom_range(99) < 31);
         end
      end
   end

   initial begin
      csr_set_type s;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_cmd(SCRIPT[i].cmd, SCRIPT[i].known, SCRIPT[i].want);
      end
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle_outputs();
         s = pick_csr(ph);
         write_csr(CSR_SLIP_ENABLE, 16'(s.en));
         write_csr(CSR_SLIP_THRESHOLD, 16'(s.thr));
         write_csr(CSR_SLIP_TIME_MS, s.ms);
         write_csr(CSR_FORWARD_CODE, 16'(s.fwd));
         write_csr(CSR_BACKWARD_CODE, 16'(s.bwd));
         receiver_idles = (ph != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // phase 4: back up the block behind a stalled receiver, then drain mid-phase
            if (ph == 4 && n == 0) rsp_hold_req = 1'b1;
            if (ph == 4 && n == ITEMS_PER_PHASE / 2) settle_outputs();
            sender_idles = !(ph == 3 || (ph == 4 && n < 20));
            send_cmd(make_cmd(), 1'b0, '0);
         end
      end
      settle_outputs();
      repeat (80) @(posedge clock);
      $display("Ran %0d updates and %0d stop/brake requests across %0d CSR settings (%0d writes).",
               updates_sent, halts_sent, NUM_PHASES + 1, csr_writes);
      $display("Checked %0d responses; slip warnings %0d, critical %0d.",
               drives_checked, warn_seen, crit_seen);
      if (mismatch_count == 0 && drive_outputs_due.size() == 0) begin
         $display("motor_speed_loop_with_slip_monitor_top regression: pass");
      end else begin
         $display("motor_speed_loop_with_slip_monitor_top regression: fail");
      end
      $finish;
   end

endmodule
